FILE: sv/bitset_with_range_any_top_assert.svh
// Assertion macros for the bit array with range query block.
// Used by the top level; expects a clock named clk and a reset named rst.
`ifndef BITSET_WITH_RANGE_ANY_TOP_ASSERT_SVH
`define BITSET_WITH_RANGE_ANY_TOP_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define BWRA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define BWRA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: sv/bwra_pkg.sv
// Types and constants shared by the bit array with range query block.
// No dependencies.
package bwra_pkg;

  localparam int INDEX_W = 10;
  localparam int RIGHT_W = 11;

  // Operation codes
  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_GET   = 2'd1;
  localparam logic [1:0] KIND_SET   = 2'd2;
  localparam logic [1:0] KIND_ANY   = 2'd3;

  // Answer source codes
  localparam logic ANS_GET = 1'b0;
  localparam logic ANS_ANY = 1'b1;

  typedef struct packed {
    logic [1:0]         kind;
    logic [INDEX_W-1:0] index;
    logic               bit_value;
    logic [RIGHT_W-1:0] right_end;
  } cmd_t;

  typedef struct packed {
    logic answer;
    logic answer_kind;
  } result_t;

endpackage

FILE: sv/bitset_with_range_any_top.sv
// Top level of the bit array with range query block: sequencer, word RAM, range unit.
// Depends on bwra_pkg, bwra_ram, bwra_mask and bitset_with_range_any_top_assert.svh.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+-----------------
//  command  | start, busy (accept when start & !busy) | cmd (cmd_t)
//  result   | done, one-cycle strobe  | result (result_t)
//
// Get, set and any walk the words from word 0 through one RAM read port,
// one word a cycle, with the range unit testing each word as it comes back;
// the walk stops at the first word that decides the answer or ends the range.
// Clear writes zeros to every word, one word write a cycle.
// Reset starts the same clearing pass, busy is high until it ends.
// The receiver cannot stall: a result is shown for one cycle, and a new beat
// may be accepted in that cycle.
`include "bitset_with_range_any_top_assert.svh"

module bitset_with_range_any_top
  import bwra_pkg::*;
#(
  parameter int BITS      = 1024,
  parameter int WORD_BITS = 64
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  cmd_t    cmd,
  output logic    done,
  output result_t result
);

  localparam int NWORDS = (BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW     = NWORDS > 1 ? $clog2(NWORDS) : 1;
  localparam int MAXB   = NWORDS * WORD_BITS + WORD_BITS;
  localparam int CWB    = $clog2(MAXB + 1);
  localparam int CW     = CWB > RIGHT_W ? CWB : RIGHT_W;
  localparam logic [AW-1:0] LAST   = AW'(NWORDS - 1);
  localparam logic [CW-1:0] BITS_C = CW'(BITS);
  localparam logic [CW-1:0] WB_C   = CW'(WORD_BITS);

  localparam logic [1:0] S_CLR  = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;

  logic [1:0]    state;
  logic [1:0]    op;
  logic          bv;
  logic [CW-1:0] lo;
  logic [CW-1:0] hi;
  logic [AW-1:0] ia;
  logic [CW-1:0] ibase;
  logic          issue_on;
  logic          evld;
  logic [AW-1:0] eaddr;
  logic [CW-1:0] ebase;

  logic                 accept;
  logic [CW-1:0]        hi_raw;
  logic [CW-1:0]        hi_next;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [WORD_BITS-1:0] rdata;
  logic [WORD_BITS-1:0] mask;
  logic                 hit;
  logic                 target;
  logic                 found_stop;
  logic                 end_word;
  logic                 fin;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // Range end: [index, index+1) for get and set, saturate everything at BITS
  assign hi_raw  = (cmd.kind == KIND_ANY) ? CW'(cmd.right_end) : (CW'(cmd.index) + CW'(1));
  assign hi_next = (hi_raw > BITS_C) ? BITS_C : hi_raw;

  bwra_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(NWORDS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ia),
    .rdata(rdata)
  );

  bwra_mask #(
    .WORD_BITS(WORD_BITS),
    .CW       (CW)
  ) u_mask (
    .word(rdata),
    .base(ebase),
    .lo  (lo),
    .hi  (hi),
    .mask(mask),
    .hit (hit)
  );

  // Decide when the word under test ends the scan
  assign target     = |mask;
  assign found_stop = target && ((op != KIND_ANY) || hit);
  assign end_word   = ((ebase + WB_C) >= hi) || (eaddr == LAST);
  assign fin        = (state == S_SCAN) && evld && (found_stop || end_word);

  // Drive RAM: zero words while clearing, write back the target word on set
  always_comb begin
    ram_re = (state == S_SCAN) && issue_on;
    if (state == S_CLR) begin
      ram_we    = 1'b1;
      ram_waddr = ia;
      ram_wdata = '0;
    end else begin
      ram_we    = fin && (op == KIND_SET) && target;
      ram_waddr = eaddr;
      ram_wdata = bv ? (rdata | mask) : (rdata & ~mask);
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      ia       <= '0;
      issue_on <= 1'b0;
      evld     <= 1'b0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLR: begin
          ia <= ia + AW'(1);
          if (ia == LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            ia       <= '0;
            ibase    <= '0;
            issue_on <= 1'b1;
            evld     <= 1'b0;
            op       <= cmd.kind;
            bv       <= cmd.bit_value;
            lo       <= CW'(cmd.index);
            hi       <= hi_next;
            state    <= (cmd.kind == KIND_CLEAR) ? S_CLR : S_SCAN;
          end
        end
        S_SCAN: begin
          // Advance the read pointer and move the issued word to test
          evld  <= issue_on;
          eaddr <= ia;
          ebase <= ibase;
          if (issue_on) begin
            ia       <= ia + AW'(1);
            ibase    <= ibase + WB_C;
            issue_on <= (ia != LAST);
          end
          if (fin) begin
            state    <= S_IDLE;
            issue_on <= 1'b0;
            evld     <= 1'b0;
            ia       <= '0;
            if (op != KIND_SET) begin
              done               <= 1'b1;
              result.answer      <= hit;
              result.answer_kind <= (op == KIND_ANY) ? ANS_ANY : ANS_GET;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Checks
  `BWRA_ASSERT(a_done_idle, done |-> !busy, "result strobe while block busy")
  `BWRA_ASSERT(a_done_pulse, done |=> !done, "result strobe longer than one cycle")
  `BWRA_ASSERT(a_clear_busy, (accept && cmd.kind == KIND_CLEAR) |=> (state == S_CLR),
               "clear command did not start the clearing pass")
  `BWRA_ASSERT_ALWAYS(a_reset_clear, rst |=> busy, "block ready right after reset")

endmodule

FILE: sv/bwra_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bwra_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/bwra_mask.sv
// Shared range unit: builds the mask of word bits inside [lo, hi) and tests it.
// Depends on nothing but its parameters.
module bwra_mask #(
  parameter int WORD_BITS = 64,
  parameter int CW        = 17
) (
  input  logic [WORD_BITS-1:0] word,
  input  logic [CW-1:0]        base,
  input  logic [CW-1:0]        lo,
  input  logic [CW-1:0]        hi,
  output logic [WORD_BITS-1:0] mask,
  output logic                 hit
);

  localparam int OW = $clog2(WORD_BITS + 1);
  localparam logic [CW-1:0] WB = CW'(WORD_BITS);

  logic [CW-1:0] dlo;
  logic [CW-1:0] dhi;
  logic [OW-1:0] olo;
  logic [OW-1:0] ohi;

  // Clamp both range ends to word-relative offsets 0..WORD_BITS
  assign dlo = lo - base;
  assign dhi = hi - base;

  always_comb begin
    if (lo <= base) begin
      olo = '0;
    end else if (dlo >= WB) begin
      olo = OW'(WORD_BITS);
    end else begin
      olo = dlo[OW-1:0];
    end
    if (hi <= base) begin
      ohi = '0;
    end else if (dhi >= WB) begin
      ohi = OW'(WORD_BITS);
    end else begin
      ohi = dhi[OW-1:0];
    end
  end

  // Mark positions olo <= p < ohi
  always_comb begin
    for (int p = 0; p < WORD_BITS; p++) begin
      mask[p] = (OW'(p) >= olo) && (OW'(p) < ohi);
    end
  end

  assign hit = |(word & mask);

endmodule
